@@ sv/imadec_pkg.sv @@
// Shared types, constants and tables for the IMA ADPCM decoder.
// No dependencies; imadec_front, imadec_back and ima_adpcm_decoder import this package.
`default_nettype none

package imadec_pkg;

   // Copies of every decoded sample (2x upsample, left and right).
   localparam int SAMPLE_REPEAT    = 4;
   localparam int RESULTS_PER_BYTE = 2 * SAMPLE_REPEAT;
   localparam int CNT_W            = $clog2(RESULTS_PER_BYTE);
   localparam logic [CNT_W-1:0] CNT_HIGH = CNT_W'(SAMPLE_REPEAT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULTS_PER_BYTE - 1);

   localparam logic [6:0] MAX_STEP_INDEX = 7'd88;

   localparam logic FUNC_HEADER = 1'b0;
   localparam logic FUNC_DATA   = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              func;
      logic signed [15:0] predictor;
      logic [6:0]        step_idx;
      logic [7:0]        data_byte;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   localparam logic [14:0] STEP_TABLE [0:88] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
      15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
      15'd27086, 15'd29794, 15'd32767
   };

   function automatic logic [14:0] step_size(input logic [6:0] idx);
      logic [14:0] val;
      if (idx > MAX_STEP_INDEX) begin
         val = STEP_TABLE[MAX_STEP_INDEX];
      end else begin
         val = STEP_TABLE[idx];
      end
      return val;
   endfunction

   // Index table is symmetric in the sign bit, so only the magnitude matters.
   function automatic logic signed [4:0] index_move(input logic [2:0] mag);
      logic signed [4:0] val;
      case (mag)
         3'd4:    val = 5'sd2;
         3'd5:    val = 5'sd4;
         3'd6:    val = 5'sd6;
         3'd7:    val = 5'sd8;
         default: val = -5'sd1;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ sv/imadec_req_if.sv @@
// Input channel of the IMA ADPCM decoder: header loads and data bytes.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface imadec_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] header_predictor;
   logic [7:0]         header_step_index;
   logic [7:0]         data_byte;

   modport source (output valid, func, header_predictor, header_step_index, data_byte,
                   input ready);
   modport sink   (input valid, func, header_predictor, header_step_index, data_byte,
                   output ready);
endinterface

`default_nettype wire

@@ sv/imadec_rsp_if.sv @@
// Result channel of the IMA ADPCM decoder: PCM samples with a last flag.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface imadec_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

`default_nettype wire

@@ sv/imadec_front.sv @@
// Front end: accepts input beats, clamps the header step index, and queues
// the classified items for the decode engine. Uses imadec_pkg, imadec_req_if.
`default_nettype none

module imadec_front (
   input  wire                  clock,
   input  wire                  reset,
   imadec_req_if.sink           req_if,
   input  wire                  pop,
   output imadec_pkg::head_type head
);
   import imadec_pkg::*;

   entry_type           entry_ff [QUEUE_DEPTH];
   entry_type           entry_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                do_pop;

   assign req_if.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign do_pop       = pop && (count_ff != '0);

   always_comb begin
      entry_in.func       = req_if.func;
      entry_in.predictor  = req_if.header_predictor;
      entry_in.data_byte  = req_if.data_byte;
      if (req_if.header_step_index > {1'b0, MAX_STEP_INDEX}) begin
         entry_in.step_idx = MAX_STEP_INDEX;
      end else begin
         entry_in.step_idx = req_if.header_step_index[6:0];
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ sv/imadec_back.sv @@
// Decode engine: works on the queue head, updates predictor and step index
// per nibble and drives the registered result channel. Uses imadec_pkg.
`default_nettype none

module imadec_back (
   input  wire                  clock,
   input  wire                  reset,
   input  imadec_pkg::head_type head,
   output logic                 pop,
   imadec_rsp_if.source         rsp_if
);
   import imadec_pkg::*;

   logic signed [15:0] predictor_ff, predictor_in;
   logic [6:0]         step_idx_ff, step_idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               decode;
   logic [3:0]         code;
   logic [14:0]        step;
   logic [16:0]        diff;
   logic signed [17:0] sum;
   logic signed [15:0] pred_new;
   logic signed [7:0]  idx_sum;
   logic [6:0]         idx_new;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign decode   = (cnt_ff == '0) || (cnt_ff == CNT_HIGH);
   assign code     = (cnt_ff == CNT_HIGH) ? head.entry.data_byte[7:4]
                                          : head.entry.data_byte[3:0];

   always_comb begin
      step = step_size(step_idx_ff);
      diff = 17'(step >> 3);
      if (code[0]) diff = diff + 17'(step >> 2);
      if (code[1]) diff = diff + 17'(step >> 1);
      if (code[2]) diff = diff + 17'(step);
      if (code[3]) begin
         sum = 18'(predictor_ff) - $signed({1'b0, diff});
      end else begin
         sum = 18'(predictor_ff) + $signed({1'b0, diff});
      end
      if (sum > 18'sd32767) begin
         pred_new = 16'sh7fff;
      end else if (sum < -18'sd32768) begin
         pred_new = 16'sh8000;
      end else begin
         pred_new = sum[15:0];
      end

      idx_sum = $signed({1'b0, step_idx_ff}) + 8'(index_move(code[2:0]));
      if (idx_sum < 0) begin
         idx_new = '0;
      end else if (idx_sum > $signed({1'b0, MAX_STEP_INDEX})) begin
         idx_new = MAX_STEP_INDEX;
      end else begin
         idx_new = idx_sum[6:0];
      end
   end

   always_comb begin
      predictor_in  = predictor_ff;
      step_idx_in   = step_idx_ff;
      cnt_in        = cnt_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      pop           = 1'b0;

      if (head.valid && head.entry.func == FUNC_HEADER) begin
         predictor_in  = head.entry.predictor;
         step_idx_in   = head.entry.step_idx;
         pop           = 1'b1;
      end else if (head.valid && head.entry.func == FUNC_DATA && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (cnt_ff == CNT_LAST);
         if (decode) begin
            predictor_in  = pred_new;
            step_idx_in   = idx_new;
            rsp_sample_in = pred_new;
         end else begin
            rsp_sample_in = predictor_ff;
         end
         if (cnt_ff == CNT_LAST) begin
            cnt_in = '0;
            pop    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         predictor_ff  <= '0;
         step_idx_ff   <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         predictor_ff  <= predictor_in;
         step_idx_ff   <= step_idx_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign rsp_if.last   = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/ima_adpcm_decoder.sv @@
// Top level of the 4-bit IMA ADPCM decoder: front end, queue, decode engine.
// Uses imadec_pkg, imadec_req_if, imadec_rsp_if, imadec_front, imadec_back.
//
//   channel | dir | payload                                             | beat
//   req_if  | in  | func, header_predictor, header_step_index, data_byte | one item
//   rsp_if  | out | sample, last                                        | one result
//
// A data byte gives 2*SAMPLE_REPEAT results, one per cycle while rsp_if is not
// stalled; a header loads predictor and step index and gives no result.
// A two-entry queue between front and back keeps input accepted while results
// drain, so bytes stream without gaps. Reset (synchronous) clears predictor,
// step index and queue. Stalls on rsp_if hold the result and fill the queue.
`default_nettype none

module ima_adpcm_decoder (
   input  wire          clock,
   input  wire          reset,
   imadec_req_if.sink   req_if,
   imadec_rsp_if.source rsp_if
);
   import imadec_pkg::*;

   head_type head;
   logic     pop;

   imadec_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .pop    (pop),
      .head   (head)
   );

   imadec_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
